### sv/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the base64 decoder
// alphabet lookup, status codes and the group record passed front to back
// ----------------------------------------------------------------------------
package b64d_pkg;

    // width of the per-message byte counter
    localparam int COUNT_W = 16;
    // largest count the counter holds, as a 32-bit value
    localparam logic [31:0] CNT_MAX =
        (COUNT_W >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << COUNT_W) - 64'd1);

    localparam int CAP_W   = 16;
    localparam int BYTES_W = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] PAD_CODE = 8'h3D;
    localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_ZERO_CAP = 2'd3;

    // one result item
    typedef struct packed {
        logic [7:0]         data;
        logic               valid;
        logic [1:0]         status;
        logic               done;
        logic [BYTES_W-1:0] count;
    } b64d_res_t;

    // all results of one group, last_idx is the index of the final one
    typedef struct packed {
        logic [1:0]      last_idx;
        b64d_res_t [2:0] res;
    } b64d_rec_t;

    // sextet value of an alphabet character, bit 6 set when not in alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        v = 7'd64;
        if (c >= 8'h41 && c <= 8'h5A)
            v = 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A)
            v = 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39)
            v = 7'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B)
            v = 7'd62;
        else if (c == 8'h2F)
            v = 7'd63;
        return v;
    endfunction

endpackage

### sv/base64_decoder_checked_top.sv
// ----------------------------------------------------------------------------
// base64_decoder_checked_top: streaming base64 decoder with checks
// one text character per item in, up to three decoded bytes per group out
// ----------------------------------------------------------------------------
// usage
//   char channel: char_valid / char_stall with char_code and last_char;
//   an item is taken at a clock edge with char_valid high and char_stall low
//   res channel: res_valid / res_stall with data_byte, byte_valid, status,
//   done_res and bytes_written; done_res marks the final item of a message
//   cfg channel: cfg_valid / cfg_ready with cfg_data, the output capacity;
//   cfg_ready is always high, write it only while the block is idle
// timing
//   one character per cycle while char_stall is low; a finished group is
//   written into the group queue and from there loaded into the output register
//   the result serializer puts out one item per cycle while res_stall is low,
//   so a group of three bytes keeps the back end busy while its items go out;
//   the four-deep group queue absorbs that, and char_stall rises only when the queue is full
// reset
//   clears group, count and drop state, empties the queue; capacity 65535
// stalling
//   res_stall holds the output register; the front keeps taking characters
//   until the queue fills
// ----------------------------------------------------------------------------
module base64_decoder_checked_top (
    input  logic                         clk,
    input  logic                         rst_n,
    // character input
    input  logic                         char_valid,
    output logic                         char_stall,
    input  logic [7:0]                   char_code,
    input  logic                         last_char,
    // capacity register write
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [b64d_pkg::CAP_W-1:0]   cfg_data,
    // result output
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic [7:0]                   data_byte,
    output logic                         byte_valid,
    output logic [1:0]                   status,
    output logic                         done_res,
    output logic [b64d_pkg::BYTES_W-1:0] bytes_written
);

    // front to queue
    logic                push;
    b64d_pkg::b64d_rec_t push_rec;
    logic                fifo_full;
    // queue to back
    logic                pop;
    logic                not_empty;
    b64d_pkg::b64d_rec_t head_rec;

    // front: decodes groups, tracks capacity and drop state
    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_code  (char_code),
        .last_char  (last_char),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_rec   (push_rec)
    );

    // group record queue
    b64d_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .pop       (pop),
        .full      (fifo_full),
        .not_empty (not_empty),
        .head_rec  (head_rec)
    );

    // back: one result item per cycle into the output register while res_stall is low
    b64d_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .not_empty     (not_empty),
        .head_rec      (head_rec),
        .pop           (pop),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .data_byte     (data_byte),
        .byte_valid    (byte_valid),
        .status        (status),
        .done_res      (done_res),
        .bytes_written (bytes_written)
    );

endmodule

### sv/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front: character intake and group decode
// gathers sextets, checks alphabet and capacity, builds at most one record per group
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      char_valid,
    output logic                      char_stall,
    input  logic [7:0]                char_code,
    input  logic                      last_char,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [b64d_pkg::CAP_W-1:0] cfg_data,
    input  logic                      fifo_full,
    output logic                      push,
    output b64d_pkg::b64d_rec_t       push_rec
);

    logic [23:0]                   store_reg, store_next;
    logic [1:0]                    pos_reg, pos_next;
    logic [3:0]                    np_reg, np_next;
    logic                          inv_reg, inv_next;
    logic [b64d_pkg::COUNT_W-1:0]  wc_reg, wc_next;
    logic                          swallow_reg, swallow_next;
    logic [b64d_pkg::CAP_W-1:0]    cap_reg;

    logic                          accept;
    logic                          is_pad;
    logic [6:0]                    sx;
    logic                          cur_inv;
    logic [23:0]                   store_upd;
    logic [3:0]                    np_upd;
    logic                          inv_upd;
    logic [7:0]                    bytes [3];
    logic [2:0]                    cond;
    logic [31:0]                   cap32;
    logic [b64d_pkg::COUNT_W-1:0]  cap_eff;
    logic [b64d_pkg::COUNT_W-1:0]  wc_t;
    logic [1:0]                    cnt;
    logic                          full_err;
    b64d_pkg::b64d_res_t [2:0]     res_v;
    logic                          complete;

    assign accept     = char_valid && !char_stall;
    assign char_stall = fifo_full;
    assign cfg_ready  = 1'b1;

    // current character merged into the group
    always_comb
    begin
        is_pad    = (char_code == b64d_pkg::PAD_CODE);
        sx        = b64d_pkg::sextet_of(char_code);
        cur_inv   = !is_pad && sx[6];
        store_upd = store_reg;
        if (!is_pad && !sx[6])
        begin
            case (pos_reg)
                2'd0:    store_upd = store_reg | {sx[5:0], 18'd0};
                2'd1:    store_upd = store_reg | {6'd0, sx[5:0], 12'd0};
                2'd2:    store_upd = store_reg | {12'd0, sx[5:0], 6'd0};
                default: store_upd = store_reg | {18'd0, sx[5:0]};
            endcase
        end
        np_upd = np_reg;
        if (!is_pad)
            np_upd = np_reg | (4'd1 << pos_reg);
        inv_upd  = inv_reg || cur_inv;
        complete = (pos_reg == 2'd3) || last_char;
    end

    // byte selection and capacity check
    always_comb
    begin
        bytes[0] = store_upd[23:16];
        bytes[1] = store_upd[15:8];
        bytes[2] = store_upd[7:0];
        for (int k = 0; k < 3; k++)
        begin
            cond[k] = (pos_reg >= 2'(k)) && np_upd[k] &&
                      ((bytes[k] != 8'd0) || np_upd[k+1]);
        end
        cap32   = 32'(cap_reg);
        cap_eff = b64d_pkg::COUNT_W'((cap32 > b64d_pkg::CNT_MAX) ? b64d_pkg::CNT_MAX : cap32);

        res_v    = '0;
        wc_t     = wc_reg;
        cnt      = 2'd0;
        full_err = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if (cond[k] && !full_err)
            begin
                if (wc_t >= cap_eff)
                begin
                    full_err          = 1'b1;
                    res_v[cnt].status = b64d_pkg::ST_FULL;
                    res_v[cnt].done   = 1'b1;
                    res_v[cnt].count  = b64d_pkg::BYTES_W'(wc_t);
                end
                else
                begin
                    wc_t             = wc_t + b64d_pkg::COUNT_W'(1);
                    res_v[cnt].data  = bytes[k];
                    res_v[cnt].valid = 1'b1;
                    res_v[cnt].count = b64d_pkg::BYTES_W'(wc_t);
                    cnt              = cnt + 2'd1;
                end
            end
        end
    end

    always_comb
    begin
        store_next   = store_reg;
        pos_next     = pos_reg;
        np_next      = np_reg;
        inv_next     = inv_reg;
        wc_next      = wc_reg;
        swallow_next = swallow_reg;
        push         = 1'b0;
        push_rec     = '0;
        if (accept)
        begin
            if (swallow_reg)
            begin
                if (last_char)
                begin
                    swallow_next = 1'b0;
                    store_next   = '0;
                    pos_next     = '0;
                    np_next      = '0;
                    inv_next     = 1'b0;
                    wc_next      = '0;
                end
            end
            else if (cap_reg == '0)
            begin
                push                   = 1'b1;
                push_rec.res[0].status = b64d_pkg::ST_ZERO_CAP;
                push_rec.res[0].done   = 1'b1;
                store_next             = '0;
                pos_next               = '0;
                np_next                = '0;
                inv_next               = 1'b0;
                wc_next                = '0;
                swallow_next           = !last_char;
            end
            else if (!complete)
            begin
                store_next = store_upd;
                np_next    = np_upd;
                inv_next   = inv_upd;
                pos_next   = pos_reg + 2'd1;
            end
            else
            begin
                store_next = '0;
                pos_next   = '0;
                np_next    = '0;
                inv_next   = 1'b0;
                if (inv_upd)
                begin
                    push                   = 1'b1;
                    push_rec.res[0].status = b64d_pkg::ST_INVALID;
                    push_rec.res[0].done   = 1'b1;
                    wc_next                = '0;
                    swallow_next           = !last_char;
                end
                else if (full_err)
                begin
                    push              = 1'b1;
                    push_rec.res      = res_v;
                    push_rec.last_idx = cnt;
                    wc_next           = '0;
                    swallow_next      = !last_char;
                end
                else if (last_char)
                begin
                    push         = 1'b1;
                    push_rec.res = res_v;
                    wc_next      = '0;
                    if (cnt == 2'd0)
                    begin
                        push_rec.res[0].done  = 1'b1;
                        push_rec.res[0].count = b64d_pkg::BYTES_W'(wc_t);
                        push_rec.last_idx     = 2'd0;
                    end
                    else
                    begin
                        push_rec.res[cnt - 2'd1].done = 1'b1;
                        push_rec.last_idx             = cnt - 2'd1;
                    end
                end
                else
                begin
                    push              = (cnt != 2'd0);
                    push_rec.res      = res_v;
                    push_rec.last_idx = cnt - 2'd1;
                    wc_next           = wc_t;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg   <= '0;
            pos_reg     <= '0;
            np_reg      <= '0;
            inv_reg     <= 1'b0;
            wc_reg      <= '0;
            swallow_reg <= 1'b0;
            cap_reg     <= b64d_pkg::CAP_RESET;
        end
        else
        begin
            store_reg   <= store_next;
            pos_reg     <= pos_next;
            np_reg      <= np_next;
            inv_reg     <= inv_next;
            wc_reg      <= wc_next;
            swallow_reg <= swallow_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
        end
    end

endmodule

### sv/b64d_fifo.sv
// ----------------------------------------------------------------------------
// b64d_fifo: short record queue between front and back
// holds decoded groups while the back end drains results
// ----------------------------------------------------------------------------
module b64d_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b64d_pkg::b64d_rec_t push_rec,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output b64d_pkg::b64d_rec_t head_rec
);

    b64d_pkg::b64d_rec_t              mem_reg [b64d_pkg::FIFO_DEPTH];
    logic [b64d_pkg::FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [b64d_pkg::FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [b64d_pkg::FIFO_AW:0]       fill_reg, fill_next;
    logic                             do_push;
    logic                             do_pop;

    assign full      = (fill_reg == (b64d_pkg::FIFO_AW+1)'(b64d_pkg::FIFO_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head_rec  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + b64d_pkg::FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + b64d_pkg::FIFO_AW'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + (b64d_pkg::FIFO_AW+1)'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - (b64d_pkg::FIFO_AW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

### sv/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back: result serializer
// walks the results of the head record into the output register
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           not_empty,
    input  b64d_pkg::b64d_rec_t            head_rec,
    output logic                           pop,
    output logic                           res_valid,
    input  logic                           res_stall,
    output logic [7:0]                     data_byte,
    output logic                           byte_valid,
    output logic [1:0]                     status,
    output logic                           done_res,
    output logic [b64d_pkg::BYTES_W-1:0]   bytes_written
);

    logic                  out_valid_reg, out_valid_next;
    b64d_pkg::b64d_res_t   out_res_reg;
    logic [1:0]            idx_reg, idx_next;
    logic                  load;
    b64d_pkg::b64d_res_t   cur_res;

    // output register refills when empty or being taken
    assign load    = not_empty && (!out_valid_reg || !res_stall);
    assign cur_res = head_rec.res[idx_reg];
    assign pop     = load && (idx_reg == head_rec.last_idx);

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (!res_stall)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = pop ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_res_reg <= cur_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    assign res_valid     = out_valid_reg;
    assign data_byte     = out_res_reg.data;
    assign byte_valid    = out_res_reg.valid;
    assign status        = out_res_reg.status;
    assign done_res      = out_res_reg.done;
    assign bytes_written = out_res_reg.count;

endmodule

### sv/b64d_checker.sv
// ----------------------------------------------------------------------------
// b64d_checker: port-level checks of the base64 decoder
// result item rules seen on the output channel
// ----------------------------------------------------------------------------
module b64d_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         res_valid,
    input logic                         res_stall,
    input logic [7:0]                   data_byte,
    input logic                         byte_valid,
    input logic [1:0]                   status,
    input logic                         done_res,
    input logic [b64d_pkg::BYTES_W-1:0] bytes_written
);

    // a stalled item stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result item dropped while stalled");

    // a byte item carries ok status and a nonzero count
    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && byte_valid |-> status == b64d_pkg::ST_OK && bytes_written != '0)
        else $error("byte item with bad status or count");

    // an item without a byte ends the message and carries a zero byte
    a_empty_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !byte_valid |-> done_res && data_byte == 8'd0)
        else $error("empty item not final");

    // invalid and zero capacity errors report no bytes
    a_err_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == b64d_pkg::ST_INVALID || status == b64d_pkg::ST_ZERO_CAP)
        |-> bytes_written == '0)
        else $error("error item with nonzero count");

endmodule

bind base64_decoder_checked_top b64d_checker u_b64d_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .data_byte     (data_byte),
    .byte_valid    (byte_valid),
    .status        (status),
    .done_res      (done_res),
    .bytes_written (bytes_written)
);
